FILE: hdl/iotu_pkg.sv
package iotu_pkg;

    localparam int MODE_W    = 2;
    localparam int PRED_W    = 10;
    localparam int LAT_W     = 16;
    localparam int NODE_W    = 10;
    localparam int CYCLE_W   = 32;
    localparam int WIDTH_W   = 5;

    localparam logic [MODE_W-1:0]  MODE_START = 2'd0;
    localparam logic [MODE_W-1:0]  MODE_PRED  = 2'd1;
    localparam logic [MODE_W-1:0]  MODE_ISSUE = 2'd2;
    localparam logic [MODE_W-1:0]  MODE_NONE  = 2'd3;

    localparam logic [CYCLE_W-1:0] CYCLE_MAX  = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_PRED,
        KIND_ISSUE
    } kind_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PRED_W-1:0] pred_index;
        logic [LAT_W-1:0]  latency;
    } in_t;

    typedef struct packed {
        logic [NODE_W-1:0]  node_index;
        logic [CYCLE_W-1:0] issue_cycle;
        logic [CYCLE_W-1:0] schedule_length;
    } out_t;

    typedef struct packed {
        kind_t             kind;
        logic [PRED_W-1:0] pred;
        logic [LAT_W-1:0]  latency;
    } op_t;

endpackage

FILE: hdl/iotu_front.sv
module iotu_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  iotu_pkg::in_t in_data,
    output logic          op_valid,
    input  logic          op_ready,
    output iotu_pkg::op_t op
);

    localparam int QD  = 2;
    localparam int PW  = $clog2(QD);
    localparam int CW  = $clog2(QD + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QD - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QD);

    iotu_pkg::op_t  q_mem [QD];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    iotu_pkg::op_t  op_in;
    logic           keep;
    logic           push;
    logic           pop;

    // Mode three carries no work and is dropped once transferred.
    always_comb
    begin
        op_in.pred    = in_data.pred_index;
        op_in.latency = in_data.latency;
        op_in.kind    = iotu_pkg::KIND_START;
        keep          = 1'b1;
        unique case (in_data.mode)
            iotu_pkg::MODE_START: op_in.kind = iotu_pkg::KIND_START;
            iotu_pkg::MODE_PRED:  op_in.kind = iotu_pkg::KIND_PRED;
            iotu_pkg::MODE_ISSUE: op_in.kind = iotu_pkg::KIND_ISSUE;
            iotu_pkg::MODE_NONE:  keep = 1'b0;
            default:              keep = 1'b0;
        endcase
    end

    assign in_ready = (count_reg != CNT_FULL);
    assign op_valid = (count_reg != '0);
    assign op       = q_mem[rd_ptr_reg];
    assign push     = in_valid && in_ready && keep;
    assign pop      = op_valid && op_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= op_in;
        end
    end

endmodule

FILE: hdl/iotu_back.sv
module iotu_back #(
    parameter int MAX_NODES = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [iotu_pkg::WIDTH_W-1:0]  issue_width,
    input  logic                          op_valid,
    output logic                          op_ready,
    input  iotu_pkg::op_t                 op,
    output logic                          out_valid,
    input  logic                          out_ready,
    output iotu_pkg::out_t                out_data
);

    localparam int AW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CMPW = (AW > iotu_pkg::PRED_W) ? AW : iotu_pkg::PRED_W;
    localparam logic [AW-1:0] NODE_LAST = AW'(MAX_NODES - 1);
    localparam int CW   = iotu_pkg::CYCLE_W;

    logic [CW-1:0]              finish_mem [MAX_NODES];

    logic [AW-1:0]              node_reg, node_next;
    logic                       s2_valid_reg, s2_valid_next;
    iotu_pkg::kind_t            s2_kind_reg;
    logic                       s2_pred_ok_reg;
    logic [iotu_pkg::LAT_W-1:0] s2_latency_reg;
    logic [AW-1:0]              s2_idx_reg;
    logic                       fwd_hit_reg;
    logic [CW-1:0]              fwd_data_reg;
    logic [CW-1:0]              rd_data_reg;

    logic [CW-1:0]              cursor_reg, cursor_next;
    logic [iotu_pkg::WIDTH_W-1:0] issued_reg, issued_next;
    logic [CW-1:0]              opr_reg, opr_next;
    logic [CW-1:0]              length_reg, length_next;
    logic                       out_valid_reg, out_valid_next;
    iotu_pkg::out_t             out_data_reg, out_data_next;

    logic                       s2_fire;
    logic                       pop;
    logic                       wr_en;
    logic [CMPW-1:0]            pred_ext;
    logic [CMPW-1:0]            node_ext;
    logic [CMPW-1:0]            idx_ext;
    logic [AW-1:0]              rd_addr;
    logic                       pred_ok;
    logic [iotu_pkg::WIDTH_W-1:0] width_eff;
    logic [CW-1:0]              cursor_inc;
    logic                       slot_full;
    logic [CW-1:0]              issue_cursor;
    logic [iotu_pkg::WIDTH_W-1:0] issue_count;
    logic [CW:0]                finish_sum;
    logic [CW-1:0]              finish;
    logic [CW-1:0]              length_new;
    logic [CW-1:0]              pred_finish;

    // The issue stage only waits when it has a result and the output register stays full.
    assign s2_fire  = s2_valid_reg
                      && (s2_kind_reg != iotu_pkg::KIND_ISSUE || !out_valid_reg || out_ready);
    assign op_ready = !s2_valid_reg || s2_fire;
    assign pop      = op_valid && op_ready;
    assign wr_en    = s2_fire && (s2_kind_reg == iotu_pkg::KIND_ISSUE);

    assign pred_ext = CMPW'(op.pred);
    assign node_ext = CMPW'(node_reg);
    assign idx_ext  = CMPW'(s2_idx_reg);
    assign rd_addr  = pred_ext[AW-1:0];
    assign pred_ok  = (pred_ext < node_ext);

    always_comb
    begin
        node_next = node_reg;
        if (pop)
        begin
            unique case (op.kind)
                iotu_pkg::KIND_START: node_next = '0;
                iotu_pkg::KIND_ISSUE: node_next = (node_reg == NODE_LAST) ? '0
                                                  : node_reg + AW'(1);
                iotu_pkg::KIND_PRED:  node_next = node_reg;
                default:              node_next = node_reg;
            endcase
        end
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (pop)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_fire)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        width_eff   = (issue_width == '0) ? iotu_pkg::WIDTH_W'(1) : issue_width;
        cursor_inc  = (cursor_reg == iotu_pkg::CYCLE_MAX) ? cursor_reg : cursor_reg + CW'(1);
        slot_full   = (issued_reg >= width_eff);
        pred_finish = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        if (opr_reg <= cursor_reg)
        begin
            issue_cursor = slot_full ? cursor_inc : cursor_reg;
            issue_count  = slot_full ? '0 : issued_reg;
        end
        else
        begin
            issue_cursor = opr_reg;
            issue_count  = '0;
        end
        finish_sum = {1'b0, issue_cursor} + (CW + 1)'(s2_latency_reg);
        finish     = finish_sum[CW] ? iotu_pkg::CYCLE_MAX : finish_sum[CW-1:0];
        length_new = (finish > length_reg) ? finish : length_reg;
    end

    always_comb
    begin
        cursor_next    = cursor_reg;
        issued_next    = issued_reg;
        opr_next       = opr_reg;
        length_next    = length_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (s2_fire)
        begin
            unique case (s2_kind_reg)
                iotu_pkg::KIND_START:
                begin
                    cursor_next = '0;
                    issued_next = '0;
                    opr_next    = '0;
                    length_next = '0;
                end
                iotu_pkg::KIND_PRED:
                begin
                    if (s2_pred_ok_reg && (pred_finish > opr_reg))
                    begin
                        opr_next = pred_finish;
                    end
                end
                iotu_pkg::KIND_ISSUE:
                begin
                    cursor_next    = issue_cursor;
                    issued_next    = issue_count + iotu_pkg::WIDTH_W'(1);
                    opr_next       = '0;
                    length_next    = length_new;
                    out_valid_next = 1'b1;
                    out_data_next.node_index      = idx_ext[iotu_pkg::NODE_W-1:0];
                    out_data_next.issue_cycle     = issue_cursor;
                    out_data_next.schedule_length = length_new;
                end
                default:
                begin
                    opr_next = opr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_reg      <= '0;
            s2_valid_reg  <= 1'b0;
            cursor_reg    <= '0;
            issued_reg    <= '0;
            opr_reg       <= '0;
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            node_reg      <= node_next;
            s2_valid_reg  <= s2_valid_next;
            cursor_reg    <= cursor_next;
            issued_reg    <= issued_next;
            opr_reg       <= opr_next;
            length_reg    <= length_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A read that meets a write to the same entry takes the new finish time.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (pop)
        begin
            s2_kind_reg    <= op.kind;
            s2_pred_ok_reg <= pred_ok;
            s2_latency_reg <= op.latency;
            s2_idx_reg     <= node_reg;
            fwd_hit_reg    <= wr_en && (s2_idx_reg == rd_addr);
            fwd_data_reg   <= finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_data_reg <= finish_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            finish_mem[s2_idx_reg] <= finish;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_issue_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_fire && s2_kind_reg == iotu_pkg::KIND_ISSUE) |=> (issued_reg != '0))
        else $error("issue count is zero after an issue");

    a_cursor_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_fire && s2_kind_reg != iotu_pkg::KIND_START) |=> (cursor_reg >= $past(cursor_reg)))
        else $error("issue cursor moved backwards without a start");

    a_write_with_room: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (!out_valid_reg || out_ready))
        else $error("table written while the result could not be stored");

    a_length_covers_issue: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.schedule_length >= out_data_reg.issue_cycle))
        else $error("schedule length below issue cycle");
`endif

endmodule

FILE: hdl/in_order_issue_timer_unit.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     in_data  (iotu_pkg::in_t)
// out       output     out_valid / out_ready   out_data (iotu_pkg::out_t)
// cfg       input      cfg_write_en            cfg_write_data (issue width)
//
// One item is taken every cycle unless the output stalls; the issue stage updates the cursor,
// the count and the operand-ready time at once; the finish table has one read and one write port.
// A result passes the queue, the stage-two registers and the output register in that order.
// Reset clears the cursor, counters, running times and the queue; the finish table is not cleared.
// A stalled output holds the issue stage, and the two-entry queue then fills before in_ready falls.
module in_order_issue_timer_unit #(
    parameter int MAX_NODES = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  iotu_pkg::in_t                 in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output iotu_pkg::out_t                out_data,
    input  logic                          cfg_write_en,
    input  logic [iotu_pkg::WIDTH_W-1:0]  cfg_write_data
);

    logic [iotu_pkg::WIDTH_W-1:0] issue_width_reg, issue_width_next;
    logic                         op_valid;
    logic                         op_ready;
    iotu_pkg::op_t                op;

    assign issue_width_next = cfg_write_en ? cfg_write_data : issue_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_width_reg <= iotu_pkg::WIDTH_W'(1);
        end
        else
        begin
            issue_width_reg <= issue_width_next;
        end
    end

    iotu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op)
    );

    iotu_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue_width (issue_width_reg),
        .op_valid    (op_valid),
        .op_ready    (op_ready),
        .op          (op),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule
